### hw/rtl/tlwc_pkg.sv
// Package for the two-level write-back cache: geometry, config indexes, controller states.
package tlwc_pkg;

  localparam int unsigned TagW     = 6;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned WordW    = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CostW    = 10;
  localparam int unsigned AccW     = 13;
  localparam int unsigned AddrW    = 20;
  localparam int unsigned BlkW     = TagW + IdxW;
  localparam int unsigned DramBytes = 1048576;
  localparam int unsigned DramBlkW  = $clog2(DramBytes / 64);
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgL1Rd   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgL1Wr   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgL2Rd   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgL2Wr   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDramRd = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDramWr = 3'd5;

  typedef enum logic [3:0] {
    StClear,     // sweep backing store to zero
    StIdle,
    StL1Look,    // L1 tag/word read data available
    StL2Look,    // L2 tags of a set available
    StDramRd,    // copy backing block into L2 way
    StDramWb,    // copy dirty L2 victim to backing store
    StL2Xfer,    // copy block L2 <-> L1 (read or write back)
    StL1Acc,     // word access in L1
    StOut        // result held
  } state_e;

endpackage

### hw/rtl/two_level_writeback_cache.sv
// Top level of the two-level write-back cache: controller, memories and cost timer.
//
// Usage: an item (operation_i, address_i, write_word_i) is accepted when in_valid_i is high
// and in_stall_o is low. Exactly one result item follows on out_valid_o, held until a
// cycle with out_stall_i low. Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) set the six 10-bit cost registers; indexes above five are dropped.
//
// Sequencing: one item at a time. An L1 hit passes from StL1Look through StL1Acc to StOut.
// An L1 miss runs block transfers over memories with one read and one write port each,
// one word per cycle: an L2 fill read, an optional backing read and dirty victim write,
// and the write back of a valid old L1 line through a second L2 lookup; the fill buffer
// is then copied into L1.
//
// Reset: costs return to 1,1,10,10,100,100, the timer to zero, all valid and dirty bits
// clear, and the backing store is swept to zero, one word per cycle; no item is accepted
// during the sweep. A stalled receiver holds the result and blocks input.
module two_level_writeback_cache
  import tlwc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [DataW-1:0]    write_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DataW-1:0]    read_word_o,
  output logic                l1_hit_o,
  output logic                l2_hit_o,
  output logic [AccW-1:0]     access_cost_o,
  output logic [DataW-1:0]    elapsed_time_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CostW-1:0]    cfg_data_i
);

  localparam int unsigned L1WA = IdxW + WordW;
  localparam int unsigned L2WA = IdxW + 1 + WordW;
  localparam int unsigned BkWA = DramBlkW + WordW;

  // memories
  logic [DataW-1:0] l1_mem [2**L1WA];
  logic [TagW-1:0]  l1_tag_mem [2**IdxW];
  logic [DataW-1:0] l2_mem [2**L2WA];
  logic [TagW-1:0]  l2_tag_mem [2**(IdxW+1)];
  logic [DataW-1:0] l2_stamp_mem [2**(IdxW+1)];
  logic [DataW-1:0] bk_mem [2**BkWA];

  logic [2**IdxW-1:0]     l1_v_q, l1_dty_q;
  logic [2**(IdxW+1)-1:0] l2_v_q, l2_dty_q;

  logic [CostW-1:0] cost_q [6];
  logic [DataW-1:0] time_q, time_d, start_q;

  state_e state_q, state_d;
  logic            op_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] wdata_q, rdata_q, rdata_d;
  logic            l1h_q, l1h_d, l2h_q, l2h_d;
  logic            phase_q, phase_d;   // 0: fill read, 1: write back of old line; in StL1Acc 1 marks the fill copy
  logic [BlkW-1:0] blk_q, blk_d;       // block in the current L2 access
  logic            way_q, way_d;
  logic [WordW:0]  cnt_q, cnt_d;       // word counter, extra bit for pipeline tail
  logic [BkWA:0]   clr_q, clr_d;
  logic [DataW-1:0] fill_buf [2**WordW]; // block fetched from L2 for the L1 fill

  // read ports
  logic [L1WA-1:0] l1_ra;
  logic [DataW-1:0] l1_rd_q;
  logic [TagW-1:0]  l1_tag_rd_q;
  logic [IdxW-1:0]  l1_tag_ra;
  logic [IdxW-1:0]  tag_set;
  logic [TagW-1:0]  l2_tag_rd_q [2];
  logic [DataW-1:0] l2_st_rd_q [2];
  logic [L2WA-1:0]  l2_ra;
  logic [DataW-1:0] l2_rd_q;
  logic [BkWA-1:0]  bk_ra;
  logic [DataW-1:0] bk_rd_q;

  // write ports
  logic             l1_we, l1_tag_we, l2_we, l2_tag_we, l2_st_we, bk_we;
  logic [L1WA-1:0]  l1_wa;
  logic [DataW-1:0] l1_wd;
  logic [L2WA-1:0]  l2_wa;
  logic [DataW-1:0] l2_wd, l2_st_wd;
  logic [BkWA-1:0]  bk_wa;
  logic [DataW-1:0] bk_wd;
  logic             buf_we;
  logic [WordW-1:0] buf_wa;

  logic [IdxW-1:0]  idx;
  logic [TagW-1:0]  tag;
  logic [WordW-1:0] wsel;
  assign tag  = addr_q[AddrW-1 -: TagW];
  assign idx  = addr_q[IdxW+WordW+1 -: IdxW];
  assign wsel = addr_q[WordW+1 -: WordW];

  // read the L1 tag of the arriving item at its accepting edge
  assign l1_tag_ra = (state_q == StIdle) ? address_i[IdxW+WordW+1 -: IdxW] : idx;

  always_ff @(posedge clk_i) begin
    l1_rd_q     <= l1_mem[l1_ra];
    l1_tag_rd_q <= l1_tag_mem[l1_tag_ra];
    l2_rd_q     <= l2_mem[l2_ra];
    bk_rd_q     <= bk_mem[bk_ra];
    for (int w = 0; w < 2; w++) begin
      l2_tag_rd_q[w] <= l2_tag_mem[{tag_set, w[0]}];
      l2_st_rd_q[w]  <= l2_stamp_mem[{tag_set, w[0]}];
    end
    if (l1_we) l1_mem[l1_wa] <= l1_wd;
    if (l1_tag_we) l1_tag_mem[idx] <= tag;
    if (l2_we) l2_mem[l2_wa] <= l2_wd;
    if (l2_tag_we) l2_tag_mem[{blk_q[IdxW-1:0], way_q}] <= blk_q[BlkW-1 -: TagW];
    if (l2_st_we) l2_stamp_mem[{blk_q[IdxW-1:0], way_q}] <= l2_st_wd;
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    if (buf_we) fill_buf[buf_wa] <= l2_rd_q;
  end

  // L2 set lookup on the latched tags of blk_q
  logic [IdxW-1:0] set;
  logic [TagW-1:0] btag;
  logic [1:0] vld, hitv;
  logic       hit_any, hit_way, vict;
  logic [DataW-1:0] st_w [2];
  // stamp written in the cycle before a lookup, forwarded past the stale read
  logic             st_fwd_q;
  logic [IdxW:0]    st_fwd_a_q;
  logic [DataW-1:0] st_fwd_d_q;
  assign set  = blk_q[IdxW-1:0];
  assign btag = blk_q[BlkW-1 -: TagW];
  assign tag_set = (state_q == StIdle || state_q == StL1Look) ? idx : blk_d[IdxW-1:0];
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      vld[w]  = l2_v_q[{set, w[0]}];
      hitv[w] = vld[w] && (l2_tag_rd_q[w] == btag);
      st_w[w] = (st_fwd_q && st_fwd_a_q == {set, w[0]}) ? st_fwd_d_q : l2_st_rd_q[w];
    end
    hit_any = hitv[0] || hitv[1];
    hit_way = !hitv[0];
    if (!vld[1])      vict = 1'b1;
    else if (!vld[0]) vict = 1'b0;
    else              vict = (st_w[1] < st_w[0]);
  end

  logic [DramBlkW-1:0] new_bb, old_bb;
  logic [BlkW-1:0] vblk;
  assign vblk   = {l2_tag_rd_q[way_q], set};
  assign new_bb = DramBlkW'(blk_q);
  assign old_bb = DramBlkW'(vblk);

  logic [WordW-1:0] c;
  assign c = cnt_q[WordW-1:0];
  logic             accept;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == StIdle || state_q == StClear);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; clr_d = clr_q; blk_d = blk_q; way_d = way_q;
    phase_d = phase_q; l1h_d = l1h_q; l2h_d = l2h_q; rdata_d = rdata_q; time_d = time_q;
    l1_ra = {idx, wsel}; l2_ra = {set, way_q, c}; bk_ra = {new_bb, c};
    l1_we = 1'b0; l1_wa = {idx, c}; l1_wd = l2_rd_q; l1_tag_we = 1'b0;
    l2_we = 1'b0; l2_wa = {set, way_q, cnt_q[WordW-1:0] - 1'b1}; l2_wd = bk_rd_q;
    l2_tag_we = 1'b0; l2_st_we = 1'b0; l2_st_wd = time_q;
    bk_we = 1'b0; bk_wa = {old_bb, cnt_q[WordW-1:0] - 1'b1}; bk_wd = l2_rd_q;
    buf_we = 1'b0; buf_wa = cnt_q[WordW-1:0] - 1'b1;
    case (state_q)
      StClear: begin
        bk_we = 1'b1; bk_wa = clr_q[BkWA-1:0]; bk_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q[BkWA]) state_d = StIdle;
      end
      StIdle: if (accept) state_d = StL1Look;
      StL1Look: begin
        l1h_d = l1_v_q[idx] && (l1_tag_rd_q == tag);
        l2h_d = 1'b1;
        if (l1h_d) state_d = StL1Acc;
        else begin
          blk_d = {tag, idx}; phase_d = 1'b0; state_d = StL2Look;
        end
      end
      StL2Look: begin
        cnt_d = '0;
        if (hit_any) begin
          way_d = hit_way; state_d = StL2Xfer;
        end else begin
          way_d = vict; state_d = StDramRd;
          time_d = time_q + DataW'(cost_q[CfgDramRd]);
          if (!phase_q) l2h_d = 1'b0;
          if (l2_v_q[{set, vict}] && l2_dty_q[{set, vict}]) begin
            state_d = StDramWb; time_d = time_d + DataW'(cost_q[CfgDramWr]);
          end
        end
      end
      StDramWb: begin
        // read L2 victim word c, write backing at c-1
        l2_ra = {set, way_q, c};
        if (cnt_q != 0) bk_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[WordW]) begin
          cnt_d = '0; state_d = StDramRd;
        end
      end
      StDramRd: begin
        bk_ra = {new_bb, c};
        if (cnt_q != 0) l2_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[WordW]) begin
          l2_tag_we = 1'b1; cnt_d = '0; state_d = StL2Xfer;
        end
      end
      StL2Xfer: begin
        if (!phase_q) begin
          // L2 -> fill buffer
          if (cnt_q != 0) buf_we = 1'b1;
        end else begin
          // old L1 line -> L2
          l1_ra = {idx, c};
          l2_wd = l1_rd_q;
          if (cnt_q != 0) l2_we = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[WordW]) begin
          time_d = time_q + DataW'(phase_q ? cost_q[CfgL2Wr] : cost_q[CfgL2Rd]);
          l2_st_we = 1'b1; l2_st_wd = time_d;
          cnt_d = '0;
          if (!phase_q && l1_v_q[idx]) begin
            phase_d = 1'b1; blk_d = {l1_tag_rd_q, idx}; state_d = StL2Look;
          end else begin
            state_d = StL1Acc; l1_tag_we = 1'b1; phase_d = 1'b1;
          end
        end
      end
      StL1Acc: begin
        if (!l1h_q && phase_q) begin
          // copy fill buffer into L1 line
          l1_we = 1'b1; l1_wa = {idx, c}; l1_wd = fill_buf[c];
          cnt_d = cnt_q + 1'b1;
          if (c == '1) begin
            phase_d = 1'b0; cnt_d = '0;
          end
        end else begin
          if (op_q) begin
            l1_we = 1'b1; l1_wa = {idx, wsel}; l1_wd = wdata_q; rdata_d = '0;
            time_d = time_q + DataW'(cost_q[CfgL1Wr]);
          end else begin
            rdata_d = l1_rd_q;
            time_d = time_q + DataW'(cost_q[CfgL1Rd]);
          end
          state_d = StOut;
        end
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // the fill copy writes L1 while the addressed word is read; a read after a fill takes its word from fill_buf
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; cnt_q <= '0; time_q <= '0;
      l1_v_q <= '0; l1_dty_q <= '0; l2_v_q <= '0; l2_dty_q <= '0;
      cost_q[CfgL1Rd] <= 10'd1; cost_q[CfgL1Wr] <= 10'd1; cost_q[CfgL2Rd] <= 10'd10;
      cost_q[CfgL2Wr] <= 10'd10; cost_q[CfgDramRd] <= 10'd100; cost_q[CfgDramWr] <= 10'd100;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; cnt_q <= cnt_d; time_q <= time_d;
      phase_q <= phase_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i <= CfgDramWr)
        cost_q[cfg_index_i] <= cfg_data_i;
      if (state_q == StDramRd && cnt_q[WordW]) begin
        l2_v_q[{set, way_q}] <= 1'b1; l2_dty_q[{set, way_q}] <= 1'b0;
      end
      if (state_q == StL2Xfer && cnt_q[WordW] && phase_q) l2_dty_q[{set, way_q}] <= 1'b1;
      if (l1_tag_we) begin
        l1_v_q[idx] <= 1'b1; l1_dty_q[idx] <= 1'b0;
      end
      if (state_q == StL1Acc && state_d == StOut && op_q) l1_dty_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i; addr_q <= address_i; wdata_q <= write_word_i; start_q <= time_q;
    end
    blk_q <= blk_d; way_q <= way_d; l1h_q <= l1h_d; l2h_q <= l2h_d; rdata_q <= rdata_d;
    st_fwd_q <= l2_st_we; st_fwd_a_q <= {blk_q[IdxW-1:0], way_q}; st_fwd_d_q <= l2_st_wd;
  end

  // after the fill copy the addressed word comes straight from the buffer
  logic hold_fill_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_fill_q <= 1'b0;
    else if (accept) hold_fill_q <= 1'b0;
    else if (state_q == StL1Acc && phase_q && !l1h_q) hold_fill_q <= 1'b1;
  end

  assign read_word_o    = (hold_fill_q && !op_q) ? fill_buf[wsel] : rdata_q;
  assign l1_hit_o       = l1h_q;
  assign l2_hit_o       = l2h_q;
  assign elapsed_time_o = time_q;
  assign access_cost_o  = AccW'(time_q - start_q);

endmodule

### test/two_level_writeback_cache_tb.sv
// Testbench for the two-level write-back cache: directed, cost and random accesses checked
// against a behavioral cache model.
`timescale 1ns / 100ps

module two_level_writeback_cache_tb;
  import tlwc_pkg::*;

  localparam int unsigned StallLimit = 1000000;  // covers the backing store sweep after reset

  typedef struct {
    logic [DataW-1:0] rdata;
    logic             l1h;
    logic             l2h;
    logic [AccW-1:0]  cost;
    logic [DataW-1:0] elapsed;
  } access_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic [AddrW-1:0] address_i = '0;
  logic [DataW-1:0] write_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DataW-1:0] read_word_o;
  logic l1_hit_o, l2_hit_o;
  logic [AccW-1:0] access_cost_o;
  logic [DataW-1:0] elapsed_time_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CostW-1:0] cfg_data_i = '0;

  two_level_writeback_cache u_top (.*);

  always #4 clk_i = ~clk_i;

  // model state
  logic [CostW-1:0] costs [6];
  logic [31:0] clock_total;
  logic        l1_v [256], l1_d [256];
  logic [5:0]  l1_t [256];
  logic [31:0] l1_w [4096];
  logic        l2_v [512], l2_d [512];
  logic [5:0]  l2_t [512];
  logic [31:0] l2_s [512];
  logic [31:0] l2_w [8192];
  logic [31:0] dram_w [262144];
  logic [31:0] blk_buf [16];

  access_res_t pending_q [$];
  int errors = 0;
  bit burst = 1'b0;
  int quiet_cycles = 0;

  initial begin
    costs = '{10'd1, 10'd1, 10'd10, 10'd10, 10'd100, 10'd100};
    clock_total = '0;
    for (int i = 0; i < 256; i++) begin
      l1_v[i] = 1'b0;
      l1_d[i] = 1'b0;
    end
    for (int i = 0; i < 512; i++) begin
      l2_v[i] = 1'b0;
      l2_d[i] = 1'b0;
    end
    for (int i = 0; i < 262144; i++) dram_w[i] = '0;
  end

  // Move one block between blk_buf and L2; returns the L2 hit.
  function automatic bit l2_move(logic [13:0] blk, bit wr);
    logic [7:0] set;
    logic [5:0] tg;
    int hit, freew, lru, way, e;
    logic [31:0] minst;
    logic [31:0] fill [16];
    set = blk[7:0];
    tg = blk[13:8];
    hit = -1;
    freew = -1;
    lru = -1;
    minst = '0;
    for (int j = 0; j < 2; j++) begin
      e = set * 2 + j;
      if (!l2_v[e]) freew = j;
      else if (l2_t[e] == tg) begin
        hit = j;
        break;
      end else if (lru < 0 || l2_s[e] < minst) begin
        lru = j;
        minst = l2_s[e];
      end
    end
    if (hit < 0) begin
      for (int k = 0; k < 16; k++) fill[k] = dram_w[blk * 16 + k];
      clock_total += costs[CfgDramRd];
      if (freew < 0) begin
        way = (lru < 0) ? 0 : lru;
        e = set * 2 + way;
        if (l2_d[e]) begin
          for (int k = 0; k < 16; k++) dram_w[{l2_t[e], set} * 16 + k] = l2_w[e * 16 + k];
          clock_total += costs[CfgDramWr];
        end
      end else begin
        way = freew;
      end
      e = set * 2 + way;
      for (int k = 0; k < 16; k++) l2_w[e * 16 + k] = fill[k];
      l2_v[e] = 1'b1;
      l2_t[e] = tg;
      l2_d[e] = 1'b0;
    end else begin
      way = hit;
    end
    e = set * 2 + way;
    if (wr) begin
      for (int k = 0; k < 16; k++) l2_w[e * 16 + k] = blk_buf[k];
      l2_d[e] = 1'b1;
      clock_total += costs[CfgL2Wr];
    end else begin
      for (int k = 0; k < 16; k++) blk_buf[k] = l2_w[e * 16 + k];
      clock_total += costs[CfgL2Rd];
    end
    l2_s[e] = clock_total;
    return hit >= 0;
  endfunction

  function automatic access_res_t cache_access(logic op, logic [AddrW-1:0] addr,
                                               logic [DataW-1:0] wd);
    access_res_t r;
    logic [5:0] tg;
    logic [7:0] idx;
    logic [3:0] wi;
    logic [31:0] start;
    logic [31:0] fill [16];
    tg = addr[19:14];
    idx = addr[13:6];
    wi = addr[5:2];
    start = clock_total;
    r.rdata = '0;
    r.l2h = 1'b1;
    r.l1h = l1_v[idx] && l1_t[idx] == tg;
    if (!r.l1h) begin
      r.l2h = l2_move({tg, idx}, 1'b0);
      fill = blk_buf;
      if (l1_v[idx]) begin
        for (int k = 0; k < 16; k++) blk_buf[k] = l1_w[idx * 16 + k];
        void'(l2_move({l1_t[idx], idx}, 1'b1));
      end
      for (int k = 0; k < 16; k++) l1_w[idx * 16 + k] = fill[k];
      l1_v[idx] = 1'b1;
      l1_t[idx] = tg;
      l1_d[idx] = 1'b0;
    end
    if (op) begin
      l1_w[idx * 16 + wi] = wd;
      l1_d[idx] = 1'b1;
      clock_total += costs[CfgL1Wr];
    end else begin
      r.rdata = l1_w[idx * 16 + wi];
      clock_total += costs[CfgL1Rd];
    end
    r.cost = AccW'(clock_total - start);
    r.elapsed = clock_total;
    return r;
  endfunction

  task automatic send_item(logic op, logic [AddrW-1:0] addr, logic [DataW-1:0] wd);
    if (!burst && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    write_word_i <= wd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(cache_access(op, addr, wd));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_cost(logic [CfgIdxW-1:0] idx, logic [CostW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx <= CfgDramWr) costs[idx] = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a few tags over a few indexes so both levels hit, conflict and evict.
  function automatic logic [AddrW-1:0] pick_addr();
    logic [AddrW-1:0] a;
    a = AddrW'($urandom());
    if ($urandom_range(0, 9) >= 2) begin
      a[19:14] = ($urandom_range(0, 7) == 0) ? 6'h3f : 6'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: a[13:6] = 8'h00;
        1: a[13:6] = 8'hff;
        default: a[13:6] = 8'($urandom_range(0, 3));
      endcase
    end
    return a;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      send_item(1'($urandom_range(0, 1)), pick_addr(), $urandom());
  endtask

  task automatic test_directed();
    send_item(1'b0, 20'h00000, '0);
    send_item(1'b0, 20'hfffff, '0);
    send_item(1'b1, 20'hfffff, 32'hffffffff);
    send_item(1'b0, 20'hffffc, '0);
    send_item(1'b1, 20'h00003, 32'ha5a5a5a5);
    send_item(1'b0, 20'h00000, '0);
    // same index, other tags: L1 conflicts, then L2 victims dirty and clean
    send_item(1'b1, 20'h04000, 32'h12345678);
    send_item(1'b0, 20'h00000, '0);
    send_item(1'b1, 20'h08004, 32'h0badf00d);
    send_item(1'b0, 20'h0c000, '0);
    send_item(1'b0, 20'h04000, '0);
    send_item(1'b0, 20'h00000, '0);
    send_item(1'b0, 20'h08004, '0);
    send_item(1'b1, 20'hfc03c, 32'h00000000);
    send_item(1'b0, 20'h0003c, '0);
    send_item(1'b0, 20'hfc03c, '0);
    send_item(1'b1, 20'h3ffc0, 32'h80000001);
    send_item(1'b0, 20'h7ffc0, '0);
    send_item(1'b0, 20'h3ffc0, '0);
    drain();
  endtask

  task automatic test_costs();
    write_cost(CfgL1Rd, 10'd0);
    write_cost(CfgL1Wr, 10'd0);
    write_cost(CfgL2Rd, 10'd0);
    write_cost(CfgL2Wr, 10'd0);
    write_cost(CfgDramRd, 10'd0);
    write_cost(CfgDramWr, 10'd0);
    run_random(40);
    drain();
    for (int i = 0; i < 6; i++) write_cost(CfgIdxW'(i), 10'h3ff);
    write_cost(3'd6, 10'h155);  // dropped
    write_cost(3'd7, 10'h2aa);  // dropped
    run_random(60);
    drain();
    for (int i = 0; i < 6; i++) write_cost(CfgIdxW'(i), 10'($urandom_range(0, 1023)));
    run_random(40);
    drain();
  endtask

  task automatic test_random();
    write_cost(CfgL1Rd, 10'd1);
    write_cost(CfgL1Wr, 10'd2);
    write_cost(CfgL2Rd, 10'd10);
    write_cost(CfgL2Wr, 10'd11);
    write_cost(CfgDramRd, 10'd100);
    write_cost(CfgDramWr, 10'd999);
    run_random(400);
    burst = 1'b1;
    run_random(250);
    burst = 1'b0;
    run_random(340);
    drain();
  endtask

  // result checker and receiver stall
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    access_res_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual read_word %h",
                 $time, read_word_o);
      end else begin
        e = pending_q.pop_front();
        check_field("read_word", e.rdata, read_word_o);
        check_field("l1_hit", e.l1h, l1_hit_o);
        check_field("l2_hit", e.l2h, l2_hit_o);
        check_field("access_cost", e.cost, access_cost_o);
        check_field("elapsed_time", e.elapsed, elapsed_time_o);
      end
    end
    out_stall_i <= !burst && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_costs();
    test_random();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
